FILE: src/qte_pkg.sv
`default_nettype none
package qte_pkg;

    localparam int ANGLE_ITERATIONS = 16;
    localparam int CORDIC_ITERS = (ANGLE_ITERATIONS > 24) ? 24 : ANGLE_ITERATIONS;

    localparam int FRONT_LAT   = 3;
    localparam int SQRT_STEPS  = 29;
    localparam int CORDIC_LAT  = CORDIC_ITERS + 2;
    localparam int TOTAL_LAT   = FRONT_LAT + SQRT_STEPS + CORDIC_LAT + 1;

    localparam int TRIG_W = 34;   // sines and cosines, 2^28 = 1.0
    localparam int REM_W  = 57;   // 1 - s^2, 2^56 = 1.0
    localparam int ROOT_W = 29;
    localparam int SQ_W   = 59;   // isqrt working width
    localparam int CX_W   = 37;   // cordic x / y
    localparam int ZA_W   = 32;   // cordic angle, 2^31 = pi

    localparam logic signed [TRIG_W-1:0] ONE_Q28 = TRIG_W'(64'sd268435456);
    localparam logic [ZA_W-1:0] HALF_PI_ACC = 32'h4000_0000;
    localparam logic [15:0] PITCH_POS_CLAMP = 16'h4000;
    localparam logic [15:0] PITCH_NEG_CLAMP = 16'hC000;

    typedef struct packed {
        logic signed [15:0] q_w;
        logic signed [15:0] q_x;
        logic signed [15:0] q_y;
        logic signed [15:0] q_z;
    } quat_t;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic               pitch_clamped;
    } euler_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sinr;
        logic signed [TRIG_W-1:0] cosr;
        logic signed [TRIG_W-1:0] sinp;
        logic signed [TRIG_W-1:0] siny;
        logic signed [TRIG_W-1:0] cosy;
        logic                     clamp;
        logic                     pos;
    } trig_t;

    // atan(2^-i)/pi * 2^31, truncated
    function automatic logic [ZA_W-1:0] atan_entry(input int idx);
        logic [ZA_W-1:0] r;
        case (idx)
            0:  r = 32'd536870912;
            1:  r = 32'd316933405;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335086;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41721;
            15: r = 32'd20860;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2607;
            19: r = 32'd1303;
            20: r = 32'd651;
            21: r = 32'd325;
            22: r = 32'd162;
            23: r = 32'd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: src/qte_front.sv
`default_nettype none
module qte_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire qte_pkg::quat_t  quat,
    output logic                 out_valid,
    output qte_pkg::trig_t       trig,
    output logic [qte_pkg::REM_W-1:0] rem
);
    import qte_pkg::*;

    logic [2:0] valid_reg;

    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg, wz_reg, xy_reg, zz_reg;

    trig_t               trig2_reg, trig2_next;
    logic [TRIG_W-1:0]   mag_reg, mag_next;
    trig_t               trig3_reg;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [55:0]         msq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    always_comb
    begin
        trig2_next.sinr = (TRIG_W'(wx_reg) + TRIG_W'(yz_reg)) <<< 1;
        trig2_next.cosr = ONE_Q28 - ((TRIG_W'(xx_reg) + TRIG_W'(yy_reg)) <<< 1);
        trig2_next.sinp = (TRIG_W'(wy_reg) - TRIG_W'(zx_reg)) <<< 1;
        trig2_next.siny = (TRIG_W'(wz_reg) + TRIG_W'(xy_reg)) <<< 1;
        trig2_next.cosy = ONE_Q28 - ((TRIG_W'(yy_reg) + TRIG_W'(zz_reg)) <<< 1);
        mag_next = trig2_next.sinp[TRIG_W-1] ? TRIG_W'(-trig2_next.sinp)
                                             : TRIG_W'(trig2_next.sinp);
        trig2_next.clamp = (mag_next >= TRIG_W'(ONE_Q28));
        trig2_next.pos   = !trig2_next.sinp[TRIG_W-1] && (trig2_next.sinp != '0);
    end

    // only meaningful when the pitch sine is below one in magnitude
    always_comb
    begin
        msq      = 56'(mag_reg[27:0]) * 56'(mag_reg[27:0]);
        rem_next = (REM_W'(1) << 56) - REM_W'(msq);
    end

    always_ff @(posedge clk)
    begin
        wx_reg <= quat.q_w * quat.q_x;
        yz_reg <= quat.q_y * quat.q_z;
        xx_reg <= quat.q_x * quat.q_x;
        yy_reg <= quat.q_y * quat.q_y;
        wy_reg <= quat.q_w * quat.q_y;
        zx_reg <= quat.q_z * quat.q_x;
        wz_reg <= quat.q_w * quat.q_z;
        xy_reg <= quat.q_x * quat.q_y;
        zz_reg <= quat.q_z * quat.q_z;
        trig2_reg <= trig2_next;
        mag_reg   <= mag_next;
        trig3_reg <= trig2_reg;
        rem_reg   <= rem_next;
    end

    assign out_valid = valid_reg[2];
    assign trig      = trig3_reg;
    assign rem       = rem_reg;
endmodule
`default_nettype wire

FILE: src/qte_isqrt.sv
`default_nettype none
module qte_isqrt (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire qte_pkg::trig_t            in_trig,
    input  wire logic [qte_pkg::REM_W-1:0] rem,
    output logic                           out_valid,
    output qte_pkg::trig_t                 out_trig,
    output logic [qte_pkg::ROOT_W-1:0]     root
);
    import qte_pkg::*;

    logic [SQRT_STEPS-1:0] valid_reg;
    logic [SQ_W-1:0]       v_reg   [SQRT_STEPS];
    logic [SQ_W-1:0]       res_reg [SQRT_STEPS];
    trig_t                 trig_reg[SQRT_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[SQRT_STEPS-2:0], in_valid};
    end

    // one result bit per stage, test bit walks down from 2^56 by 2^2
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            logic [SQ_W-1:0] v_in;
            logic [SQ_W-1:0] res_in;
            logic [SQ_W-1:0] bit_k;
            logic [SQ_W-1:0] trial;
            bit_k  = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
            v_in   = (k == 0) ? SQ_W'(rem) : v_reg[(k == 0) ? 0 : k - 1];
            res_in = (k == 0) ? '0 : res_reg[(k == 0) ? 0 : k - 1];
            trial  = res_in + bit_k;
            if (v_in >= trial)
            begin
                v_reg[k]   <= v_in - trial;
                res_reg[k] <= (res_in >> 1) + bit_k;
            end
            else
            begin
                v_reg[k]   <= v_in;
                res_reg[k] <= res_in >> 1;
            end
            trig_reg[k] <= (k == 0) ? in_trig : trig_reg[(k == 0) ? 0 : k - 1];
        end
    end

    assign out_valid = valid_reg[SQRT_STEPS-1];
    assign out_trig  = trig_reg[SQRT_STEPS-1];
    assign root      = res_reg[SQRT_STEPS-1][ROOT_W-1:0];
endmodule
`default_nettype wire

FILE: src/qte_cordic.sv
`default_nettype none
module qte_cordic (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic signed [qte_pkg::TRIG_W-1:0] sn,
    input  wire logic signed [qte_pkg::TRIG_W-1:0] cs,
    output logic                                   out_valid,
    output logic [15:0]                            angle
);
    import qte_pkg::*;

    logic [CORDIC_ITERS:0]    valid_reg;
    logic                     out_valid_reg;
    logic signed [CX_W-1:0]   x_reg [CORDIC_ITERS+1];
    logic signed [CX_W-1:0]   y_reg [CORDIC_ITERS+1];
    logic [ZA_W-1:0]          z_reg [CORDIC_ITERS+1];
    logic [CORDIC_ITERS:0]    zero_reg;
    logic [15:0]              angle_reg;
    logic [ZA_W-1:0]          rounded;

    logic signed [CX_W-1:0]   xs, ys;

    assign xs = CX_W'(cs);
    assign ys = CX_W'(sn);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= {valid_reg[CORDIC_ITERS-1:0], in_valid};
            out_valid_reg <= valid_reg[CORDIC_ITERS];
        end
    end

    always_ff @(posedge clk)
    begin
        // left half plane: pre-rotate by a quarter turn
        zero_reg[0] <= (sn == '0) && (cs == '0);
        if (cs < 0)
        begin
            if (sn >= 0)
            begin
                x_reg[0] <= ys;
                y_reg[0] <= -xs;
                z_reg[0] <= HALF_PI_ACC;
            end
            else
            begin
                x_reg[0] <= -ys;
                y_reg[0] <= xs;
                z_reg[0] <= -HALF_PI_ACC;
            end
        end
        else
        begin
            x_reg[0] <= xs;
            y_reg[0] <= ys;
            z_reg[0] <= '0;
        end

        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            zero_reg[i+1] <= zero_reg[i];
            if (y_reg[i] > 0)
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + atan_entry(i);
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - atan_entry(i);
            end
        end

        angle_reg <= zero_reg[CORDIC_ITERS] ? '0 : rounded[31:16];
    end

    // round half up to 16 bits
    assign rounded   = z_reg[CORDIC_ITERS] + 32'h0000_8000;
    assign out_valid = out_valid_reg;
    assign angle     = angle_reg;
endmodule
`default_nettype wire

FILE: src/quaternion_to_euler_angles_core.sv
// channel   handshake             payload              direction
// command   start / busy          quat (quat_t)        in
// result    done (one cycle)      result (euler_t)     out
//
// one quaternion word per cycle; busy never rises
// a word passes through the products and sums, then 29 stages of square
// root, then one cordic stage per iteration of the angle
// reset clears only the valid bits; in-flight words are dropped
// results cannot be held off, so nothing ever stalls
`default_nettype none
module quaternion_to_euler_angles_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire qte_pkg::quat_t  quat,
    output logic                 done,
    output qte_pkg::euler_t      result
);
    import qte_pkg::*;

    logic                f_valid;
    trig_t               f_trig;
    logic [REM_W-1:0]    f_rem;

    logic                s_valid;
    trig_t               s_trig;
    logic [ROOT_W-1:0]   s_root;

    logic                r_valid, p_valid, y_valid;
    logic [15:0]         r_angle, p_angle, y_angle;

    logic [CORDIC_LAT-1:0] clamp_pipe_reg;
    logic [CORDIC_LAT-1:0] pos_pipe_reg;

    logic    done_reg;
    euler_t  result_reg, result_next;

    assign busy = 1'b0;

    qte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .quat      (quat),
        .out_valid (f_valid),
        .trig      (f_trig),
        .rem       (f_rem)
    );

    qte_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_trig   (f_trig),
        .rem       (f_rem),
        .out_valid (s_valid),
        .out_trig  (s_trig),
        .root      (s_root)
    );

    qte_cordic u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .sn        (s_trig.sinr),
        .cs        (s_trig.cosr),
        .out_valid (r_valid),
        .angle     (r_angle)
    );

    qte_cordic u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .sn        (s_trig.sinp),
        .cs        (signed'(TRIG_W'(s_root))),
        .out_valid (p_valid),
        .angle     (p_angle)
    );

    qte_cordic u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .sn        (s_trig.siny),
        .cs        (s_trig.cosy),
        .out_valid (y_valid),
        .angle     (y_angle)
    );

    // pitch clamp flags ride alongside the cordic
    always_ff @(posedge clk)
    begin
        clamp_pipe_reg <= {clamp_pipe_reg[CORDIC_LAT-2:0], s_trig.clamp};
        pos_pipe_reg   <= {pos_pipe_reg[CORDIC_LAT-2:0], s_trig.pos};
    end

    always_comb
    begin
        result_next.roll_angle    = r_angle;
        result_next.yaw_angle     = y_angle;
        result_next.pitch_clamped = clamp_pipe_reg[CORDIC_LAT-1];
        if (clamp_pipe_reg[CORDIC_LAT-1])
            result_next.pitch_angle = pos_pipe_reg[CORDIC_LAT-1] ? PITCH_POS_CLAMP
                                                                 : PITCH_NEG_CLAMP;
        else
            result_next.pitch_angle = p_angle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= r_valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##TOTAL_LAT done)
        else $error("accepted word did not come out on time");

    a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##TOTAL_LAT !done)
        else $error("result without a matching accepted word");

    a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> (p_valid && y_valid))
        else $error("cordic lanes out of step");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.pitch_clamped) |->
            (result.pitch_angle == 16'sd16384 || result.pitch_angle == -16'sd16384))
        else $error("clamped pitch not at a quarter turn");
endmodule
`default_nettype wire
